@@ sv/rglap_pkg.sv @@
// Package for the RSSI gate lap detector: widths, register indexes, reset values and types.
`default_nettype none

package rglap_pkg;

  // Width of an RSSI sample and of the trigger level.
  localparam int unsigned RSSI_BITS = 12;
  // Width of the threshold and offset registers.
  localparam int unsigned THR_BITS  = 12;
  localparam int unsigned TIME_BITS = 32;
  // Common width for comparisons that mix RSSI values and thresholds.
  localparam int unsigned CMP_BITS  = (RSSI_BITS > THR_BITS) ? RSSI_BITS : THR_BITS;
  localparam int unsigned CFG_DATA_BITS = TIME_BITS;
  localparam int unsigned CFG_IDX_BITS  = 2;

  localparam logic [RSSI_BITS-1:0] TRIGGER_RESET = RSSI_BITS'(10);
  localparam logic [THR_BITS-1:0]  CAL_OFFSET_RESET = THR_BITS'(15);
  localparam logic [THR_BITS-1:0]  EXIT_THR_RESET = THR_BITS'(60);
  localparam logic [THR_BITS-1:0]  EXIT_THR_CAL_RESET = THR_BITS'(120);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIN_LAP_TIME    = 2'd0,
    CFG_CAL_OFFSET      = 2'd1,
    CFG_EXIT_THR        = 2'd2,
    CFG_EXIT_THR_CAL    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [RSSI_BITS-1:0] rssi;
    logic [TIME_BITS-1:0] now_ms;
    logic                 enter_calibration;
  } in_t;

  typedef struct packed {
    logic                 lap_detected;
    logic [TIME_BITS-1:0] lap_time_ms;
    logic [RSSI_BITS-1:0] lap_exit_rssi;
    logic [RSSI_BITS-1:0] trigger_now;
    logic                 in_gate;
    logic                 calibrating_now;
  } out_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] min_lap_time;
    logic [THR_BITS-1:0]  calibration_offset;
    logic [THR_BITS-1:0]  exit_threshold;
    logic [THR_BITS-1:0]  exit_threshold_calibrating;
  } cfg_t;

  typedef struct packed {
    logic                 gate_reached;
    logic                 calibrating;
    logic [RSSI_BITS-1:0] trigger_level;
    logic [RSSI_BITS-1:0] peak_rssi;
    logic [TIME_BITS-1:0] peak_time;
    logic [TIME_BITS-1:0] lap_start_time;
    logic [TIME_BITS-1:0] last_lap_end_time;
  } state_t;

endpackage

`default_nettype wire

@@ sv/rglap_cfg.sv @@
// Configuration register file of the RSSI gate lap detector.
`default_nettype none

module rglap_cfg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [rglap_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [rglap_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  output rglap_pkg::cfg_t                         cfg_o
);
  import rglap_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_lap_time               <= '0;
      cfg_q.calibration_offset         <= CAL_OFFSET_RESET;
      cfg_q.exit_threshold             <= EXIT_THR_RESET;
      cfg_q.exit_threshold_calibrating <= EXIT_THR_CAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_LAP_TIME: cfg_q.min_lap_time <= cfg_wdata_i[TIME_BITS-1:0];
        CFG_CAL_OFFSET:   cfg_q.calibration_offset <= cfg_wdata_i[THR_BITS-1:0];
        CFG_EXIT_THR:     cfg_q.exit_threshold <= cfg_wdata_i[THR_BITS-1:0];
        CFG_EXIT_THR_CAL: cfg_q.exit_threshold_calibrating <= cfg_wdata_i[THR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ sv/rglap_step.sv @@
// Per-sample lap detection logic: next tracker state and the result of one sample.
`default_nettype none

module rglap_step (
  input  wire rglap_pkg::in_t    in_i,
  input  wire rglap_pkg::cfg_t   cfg_i,
  input  wire rglap_pkg::state_t st_i,
  output rglap_pkg::state_t      st_o,
  output rglap_pkg::out_t        res_o
);
  import rglap_pkg::*;

  logic [TIME_BITS-1:0] holdoff_end;
  logic                 window_open;
  logic [CMP_BITS-1:0]  rssi_w;
  logic [CMP_BITS-1:0]  offset_w;
  logic [CMP_BITS-1:0]  cand_w;
  logic [CMP_BITS-1:0]  trig_w;
  logic [CMP_BITS-1:0]  thr_w;
  logic                 lap;

  always_comb begin
    st_o  = st_i;
    lap   = 1'b0;
    res_o = '0;

    if (in_i.enter_calibration) begin
      st_o.calibrating = 1'b1;
    end

    holdoff_end = st_i.last_lap_end_time + cfg_i.min_lap_time;
    window_open = (in_i.now_ms >= holdoff_end);

    rssi_w   = CMP_BITS'(in_i.rssi);
    offset_w = CMP_BITS'(cfg_i.calibration_offset);
    cand_w   = rssi_w - offset_w;

    if (window_open) begin
      if (!st_i.gate_reached && (in_i.rssi > st_i.trigger_level)) begin
        st_o.gate_reached = 1'b1;
      end
      if (in_i.rssi > st_i.peak_rssi) begin
        st_o.peak_rssi = in_i.rssi;
        st_o.peak_time = in_i.now_ms;
      end
    end

    // The trigger may only rise while calibrating and inside the gate.
    if (window_open && st_o.gate_reached && st_o.calibrating && (rssi_w >= offset_w) &&
        (cand_w > CMP_BITS'(st_i.trigger_level))) begin
      st_o.trigger_level = cand_w[RSSI_BITS-1:0];
    end

    trig_w = CMP_BITS'(st_o.trigger_level);
    thr_w  = st_o.calibrating ? CMP_BITS'(cfg_i.exit_threshold_calibrating)
                              : CMP_BITS'(cfg_i.exit_threshold);

    if (window_open && st_o.gate_reached && (trig_w > thr_w) &&
        (rssi_w < (trig_w - thr_w))) begin
      lap                     = 1'b1;
      res_o.lap_time_ms       = st_o.peak_time - st_i.lap_start_time;
      res_o.lap_exit_rssi     = in_i.rssi;
      st_o.gate_reached       = 1'b0;
      st_o.lap_start_time     = st_o.peak_time;
      st_o.last_lap_end_time  = in_i.now_ms;
      st_o.peak_rssi          = '0;
      st_o.peak_time          = '0;
      st_o.calibrating        = 1'b0;
    end

    res_o.lap_detected    = lap;
    res_o.trigger_now     = st_o.trigger_level;
    res_o.in_gate         = st_o.gate_reached;
    res_o.calibrating_now = st_o.calibrating;
  end

endmodule

`default_nettype wire

@@ sv/rssi_gate_lap_detector_core.sv @@
// Top level of the RSSI gate lap detector: input register, tracker state and result register.
// Usage:
//   Each input transaction carries one RSSI sample, its millisecond timestamp and a
//   request to enter calibration mode. Each accepted sample produces exactly one result
//   transaction: a lap flag with the lap time and exit RSSI, plus the trigger level,
//   gate status and calibration status after that sample.
//   Both channels use valid and ready. A sample is captured into the input register,
//   handled by the combinational step logic against the tracker state once the output
//   register is free or being emptied, and its result is loaded into the output
//   register at the same edge as the state update. Throughput is one sample per cycle
//   while the receiver does not stall; it is set by the loop through the tracker state
//   registers, which carry one sample's update to the next. When the receiver stalls,
//   the result stays in the output register and the held sample waits in the input
//   register; in_ready_o falls only when both are full.
//   Configuration writes take effect at the edge where cfg_we_i is high and are to be
//   made only while no sample is in flight.
//   Reset is asynchronous and active low: it empties both registers, restores the
//   tracker state (trigger level 10, everything else zero) and the register defaults.
`default_nettype none

module rssi_gate_lap_detector_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire rglap_pkg::in_t                      in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output rglap_pkg::out_t                          out_data_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [rglap_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [rglap_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i
);
  import rglap_pkg::*;

  cfg_t   cfg;
  in_t    in_q;
  logic   in_valid_q;
  state_t st_q, st_d;
  out_t   res_d, out_q;
  logic   out_valid_q;
  logic   advance;

  rglap_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rglap_step u_step (
    .in_i  (in_q),
    .cfg_i (cfg),
    .st_i  (st_q),
    .st_o  (st_d),
    .res_o (res_d)
  );

  // The held sample is handled whenever the result register is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.gate_reached      <= 1'b0;
      st_q.calibrating       <= 1'b0;
      st_q.trigger_level     <= TRIGGER_RESET;
      st_q.peak_rssi         <= '0;
      st_q.peak_time         <= '0;
      st_q.lap_start_time    <= '0;
      st_q.last_lap_end_time <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // A lap end always leaves the gate and clears calibration mode.
  a_lap_clears_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.lap_detected |-> !out_q.in_gate && !out_q.calibrating_now)
    else $error("lap result with gate or calibration still set");

  // Without a lap the lap fields read as zero.
  a_no_lap_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.lap_detected |-> (out_q.lap_time_ms == '0) &&
                                           (out_q.lap_exit_rssi == '0))
    else $error("lap fields non-zero without a lap");

  // An empty input register always takes a new sample.
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input stalled while the input register is empty");

  // A handled sample shows up as a result in the next cycle.
  a_advance_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("handled sample produced no result");
`endif

endmodule

`default_nettype wire
